// ===== rtl/md5_pkg.sv =====
package md5_pkg;

  // Message item as it arrives from the producer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       final_item;
  } in_item_t;

  // One digest word as it leaves towards the consumer.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int unsigned WordIdxW = 4;
  localparam int unsigned BytePosW = 6;
  localparam int unsigned RoundW   = 6;
  localparam int unsigned ByteCntW = 61;

  // Work handed from the front end to the compression engine.
  typedef struct packed {
    logic [WordIdxW-1:0] word_idx;
    logic [31:0]         data;
    logic                compress;
    logic                emit;
  } cmd_t;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic [3:0][31:0] ChainInit = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [7:0]          PadMark   = 8'h80;
  localparam logic [1:0]          LastWord  = 2'd3;
  localparam logic [WordIdxW-1:0] LastSlot  = 4'd15;
  localparam logic [WordIdxW-1:0] LenLoSlot = 4'd14;
  localparam logic [RoundW-1:0]   LastRound = 6'd63;
  localparam logic [BytePosW-1:0] LastByte  = 6'd63;

  typedef enum logic {
    FrontIdle,
    FrontPad
  } front_state_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackRound,
    BackAdd
  } back_state_e;

  function automatic logic [31:0] sine_rom(input logic [RoundW-1:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Rotation amount, selected by round group and the low two round bits.
  function automatic logic [4:0] shift_rom(input logic [3:0] sel);
    logic [4:0] s;
    unique case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

// ===== rtl/md5_cmd_fifo.sv =====
module md5_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  md5_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output md5_pkg::cmd_t rd_data_o,
  output logic          empty_o
);
  import md5_pkg::*;

  cmd_t                 mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0]   cnt_q;
  logic                 do_wr, do_rd;

  assign full_o    = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/md5_front.sv =====
module md5_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  md5_pkg::in_item_t item_i,
  output logic             cmd_wr_o,
  output md5_pkg::cmd_t    cmd_o,
  input  logic             cmd_full_i
);
  import md5_pkg::*;

  front_state_e          state_q, state_d;
  logic [BytePosW-1:0]   pos_q, pos_d;
  logic [ByteCntW-1:0]   cnt_q, cnt_d;
  logic [31:0]           wacc_q, wacc_d;
  logic [WordIdxW-1:0]   padw_q, padw_d;
  logic                  first_q, first_d;
  logic                  lastblk_q, lastblk_d;
  logic                  accept;
  logic [31:0]           merged;
  logic [31:0]           pad_word;
  logic [BytePosW-1:0]   pos_next;

  assign full   = (state_q != FrontIdle) || cmd_full_i;
  assign accept = push && !full;

  // Place the incoming byte in its lane of the word being assembled.
  always_comb begin
    merged = wacc_q;
    for (int l = 0; l < 4; l++) begin
      if (pos_q[1:0] == 2'(l)) begin
        merged[8*l +: 8] = item_i.data_byte;
      end
    end
  end

  // First padding word: bytes already taken, the marker, then zeros.
  always_comb begin
    pad_word = '0;
    for (int l = 0; l < 4; l++) begin
      if (2'(l) < pos_q[1:0]) begin
        pad_word[8*l +: 8] = wacc_q[8*l +: 8];
      end else if (2'(l) == pos_q[1:0]) begin
        pad_word[8*l +: 8] = PadMark;
      end
    end
  end

  assign pos_next = item_i.has_byte ? pos_q + 1'b1 : pos_q;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    wacc_d    = wacc_q;
    padw_d    = padw_q;
    first_d   = first_q;
    lastblk_d = lastblk_q;
    cmd_wr_o  = 1'b0;
    cmd_o     = '{word_idx: pos_q[5:2], data: merged,
                  compress: (pos_q == LastByte), emit: 1'b0};
    unique case (state_q)
      FrontIdle: begin
        if (accept) begin
          if (item_i.has_byte) begin
            wacc_d   = merged;
            pos_d    = pos_next;
            cnt_d    = cnt_q + 1'b1;
            cmd_wr_o = (pos_q[1:0] == 2'b11);
          end
          if (item_i.final_item) begin
            state_d   = FrontPad;
            padw_d    = pos_next[5:2];
            first_d   = 1'b1;
            lastblk_d = (pos_next[5:3] != 3'b111);
          end
        end
      end
      FrontPad: begin
        cmd_o.word_idx = padw_q;
        cmd_o.compress = (padw_q == LastSlot);
        cmd_o.emit     = (padw_q == LastSlot) && lastblk_q;
        if (first_q) begin
          cmd_o.data = pad_word;
        end else if (lastblk_q && padw_q == LenLoSlot) begin
          cmd_o.data = {cnt_q[28:0], 3'b000};
        end else if (lastblk_q && padw_q == LastSlot) begin
          cmd_o.data = cnt_q[60:29];
        end else begin
          cmd_o.data = '0;
        end
        if (!cmd_full_i) begin
          cmd_wr_o = 1'b1;
          first_d  = 1'b0;
          padw_d   = padw_q + 1'b1;
          if (padw_q == LastSlot) begin
            if (lastblk_q) begin
              state_d = FrontIdle;
              pos_d   = '0;
              cnt_d   = '0;
              wacc_d  = '0;
            end else begin
              lastblk_d = 1'b1;
            end
          end
        end
      end
      default: state_d = FrontIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FrontIdle;
      pos_q     <= '0;
      cnt_q     <= '0;
      padw_q    <= '0;
      first_q   <= 1'b0;
      lastblk_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      padw_q    <= padw_d;
      first_q   <= first_d;
      lastblk_q <= lastblk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wacc_q <= wacc_d;
  end

endmodule

// ===== rtl/md5_back.sv =====
module md5_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               cmd_rd_o,
  input  md5_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               empty,
  input  logic               pop,
  output md5_pkg::out_item_t out_item_o
);
  import md5_pkg::*;

  back_state_e         state_q, state_d;
  logic [31:0]         buf_q [16];
  logic [3:0][31:0]    chain_q;
  logic [3:0][31:0]    regs_q;
  logic [3:0][31:0]    sum;
  logic [3:0][31:0]    out_q;
  logic [RoundW-1:0]   rnd_q;
  logic                emit_q;
  logic                out_vld_q;
  logic [1:0]          rd_q;
  logic                load_round, do_round, add_chain, do_emit;
  logic [3:0]          i4, g;
  logic [31:0]         a, b, c, d, fn, t;

  assign cmd_rd_o = (state_q == BackIdle) && !cmd_empty_i;

  // One MD5 step per cycle: message word select, round function, rotate.
  assign i4 = rnd_q[3:0];
  assign a  = regs_q[0];
  assign b  = regs_q[1];
  assign c  = regs_q[2];
  assign d  = regs_q[3];

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: begin
        fn = (b & c) | (~b & d);
        g  = i4;
      end
      2'd1: begin
        fn = (d & b) | (~d & c);
        g  = i4 + {i4[1:0], 2'b00} + 4'd1;
      end
      2'd2: begin
        fn = b ^ c ^ d;
        g  = i4 + {i4[2:0], 1'b0} + 4'd5;
      end
      default: begin
        fn = c ^ (b | ~d);
        g  = {i4[0], 3'b000} - i4;
      end
    endcase
  end

  assign t = a + fn + sine_rom(rnd_q) + buf_q[g];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = chain_q[k] + regs_q[k];
    end
  end

  always_comb begin
    state_d    = state_q;
    load_round = 1'b0;
    do_round   = 1'b0;
    add_chain  = 1'b0;
    do_emit    = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (cmd_rd_o && cmd_i.compress) begin
          load_round = 1'b1;
          state_d    = BackRound;
        end
      end
      BackRound: begin
        do_round = 1'b1;
        if (rnd_q == LastRound) begin
          state_d = BackAdd;
        end
      end
      BackAdd: begin
        if (!emit_q) begin
          add_chain = 1'b1;
          state_d   = BackIdle;
        end else if (!out_vld_q) begin
          do_emit = 1'b1;
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q   <= ChainInit;
      regs_q    <= '0;
      rnd_q     <= '0;
      emit_q    <= 1'b0;
      out_vld_q <= 1'b0;
      rd_q      <= '0;
    end else begin
      if (load_round) begin
        regs_q <= chain_q;
        rnd_q  <= '0;
        emit_q <= cmd_i.emit;
      end else if (do_round) begin
        regs_q[0] <= d;
        regs_q[1] <= b + rotl32(t, shift_rom({rnd_q[5:4], rnd_q[1:0]}));
        regs_q[2] <= b;
        regs_q[3] <= c;
        rnd_q     <= rnd_q + 1'b1;
      end
      if (add_chain) begin
        chain_q <= sum;
      end else if (do_emit) begin
        chain_q <= ChainInit;
      end
      if (do_emit) begin
        out_vld_q <= 1'b1;
        rd_q      <= '0;
      end else if (pop && out_vld_q) begin
        rd_q <= rd_q + 1'b1;
        if (rd_q == LastWord) begin
          out_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      buf_q[cmd_i.word_idx] <= cmd_i.data;
    end
    if (do_emit) begin
      out_q <= sum;
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = '{digest_word: out_q[rd_q], word_index: rd_q,
                        last_word: (rd_q == LastWord)};

  // The round counter only moves inside a block's rounds.
  a_rnd_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BackRound) |-> (rnd_q == '0))
    else $error("round counter non-zero outside rounds");

  // A digest handover restarts the chain for the next message.
  a_emit_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BackAdd && emit_q && !out_vld_q) |=>
      (out_vld_q && chain_q == ChainInit && state_q == BackIdle))
    else $error("digest handover did not restart the chain");

  // The held digest is released only when its last word is taken.
  a_out_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_vld_q) |-> $past(pop && rd_q == LastWord))
    else $error("digest released before its last word was taken");

  // No new command is taken while a block is in flight.
  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BackRound || state_q == BackAdd) |-> !cmd_rd_o)
    else $error("command taken during compression");

endmodule

// ===== rtl/md5_message_digest_core.sv =====
// MD5 digest core. Bytes are taken at up to one beat per cycle while the command queue has room
// and no padding words are being generated; every fourth byte posts one word, and the round unit
// handles a full block as one pop, the rounds and one chain add. A final beat is followed by the
// padding words up to the end of its block (16 more when the tail has 56 bytes or more); the first
// digest word appears once the last block has been compressed.
// Reset is asynchronous and active low, restores the initial chain value and needs no clearing pass.
module md5_message_digest_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  md5_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output md5_pkg::out_item_t out_item_o
);
  import md5_pkg::*;

  // The front end packs bytes into little-endian words, keeps the byte count and
  // generates the padding and length words itself. Each word travels to the back
  // end as one command, which says whether the block is complete and whether the
  // digest is due once it has been compressed.
  cmd_t fr_cmd, bk_cmd;
  logic fr_wr, q_full, q_empty, bk_rd;

  md5_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (in_item_i),
    .cmd_wr_o   (fr_wr),
    .cmd_o      (fr_cmd),
    .cmd_full_i (q_full)
  );

  // A short command queue lets the front end keep taking beats while the
  // round unit works through a block.
  md5_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_wr),
    .wr_data_i (fr_cmd),
    .full_o    (q_full),
    .rd_i      (bk_rd),
    .rd_data_o (bk_cmd),
    .empty_o   (q_empty)
  );

  // The back end holds the block buffer, the chain value and the round
  // registers, runs one round per cycle and keeps the finished digest in its
  // own output registers, so that the next message can be absorbed while the
  // four digest words are still being drained.
  md5_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_rd_o    (bk_rd),
    .cmd_i       (bk_cmd),
    .cmd_empty_i (q_empty),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== verif/tb_md5_message_digest_core.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the streaming MD5 core.
//
// Message items are queued by the stimulus process and presented by a driver on the falling
// edge. A monitor on the rising edge sees every beat on both sides. Each accepted item is folded
// into a local MD5 model, and a final item adds four digest words to the list of words still
// owed by the core. Each word that the core hands over is checked against the oldest one owed.
module tb_md5_message_digest_core;

  localparam int unsigned ClkPeriod = 10;

  // No beat on either side for this long means the core has hung. The slowest legal gap is a
  // final item with a tail of 56 bytes or more: up to 18 padding words and two compressions, with
  // each digest word then held back by a receiver that stalls in 88 percent of cycles.
  localparam int unsigned QuietLimit = 4000;

  // Cycles allowed after the last digest word for anything unexpected to appear.
  localparam int unsigned TailCycles = 300;

  // Number of non-idle items aimed at in each random phase.
  localparam int unsigned PhaseItems = 35;

  localparam logic [31:0] ChainA  = 32'h67452301;
  localparam logic [31:0] ChainB  = 32'hEFCDAB89;
  localparam logic [31:0] ChainC  = 32'h98BADCFE;
  localparam logic [31:0] ChainD  = 32'h10325476;
  localparam logic [7:0]  PadMark = 8'h80;

  // Left-rotation amounts: entry (round group * 4 + round % 4), entry 0 written last.
  localparam logic [15:0][4:0] RotAmount = {
    5'd21, 5'd15, 5'd10, 5'd6,  5'd23, 5'd16, 5'd11, 5'd4,
    5'd20, 5'd14, 5'd9,  5'd5,  5'd22, 5'd17, 5'd12, 5'd7
  };

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                push       = 1'b0;
  logic                pop        = 1'b0;
  md5_pkg::in_item_t   in_item_i  = '0;
  logic                full;
  logic                empty;
  md5_pkg::out_item_t  out_item_o;

  // Model state: chaining value, block buffer, message length in bits and the next free slot.
  logic [31:0] chain_val   [4];
  logic [31:0] block_words [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  md5_pkg::in_item_t  message_items [$];  // items waiting to be sent, oldest first
  md5_pkg::out_item_t digest_due    [$];  // digest words owed by the core, oldest first

  int unsigned items_queued   = 0;
  int unsigned fault_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_beat        = 1'b0;
  bit          out_beat       = 1'b0;
  bit          out_owed       = 1'b0;
  bit          send_go        = 1'b0;
  md5_pkg::out_item_t want_word;

  md5_message_digest_core uut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_item_i,
    .empty,
    .pop,
    .out_item_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Per-round additive constants, the integer part of abs(sin(i + 1)) * 2^32.
  function automatic logic [31:0] round_const(input int unsigned i);
    logic [31:0] k;
    case (i)
      0:  k = 32'hd76aa478;  1:  k = 32'he8c7b756;  2:  k = 32'h242070db;  3:  k = 32'hc1bdceee;
      4:  k = 32'hf57c0faf;  5:  k = 32'h4787c62a;  6:  k = 32'ha8304613;  7:  k = 32'hfd469501;
      8:  k = 32'h698098d8;  9:  k = 32'h8b44f7af;  10: k = 32'hffff5bb1;  11: k = 32'h895cd7be;
      12: k = 32'h6b901122;  13: k = 32'hfd987193;  14: k = 32'ha679438e;  15: k = 32'h49b40821;
      16: k = 32'hf61e2562;  17: k = 32'hc040b340;  18: k = 32'h265e5a51;  19: k = 32'he9b6c7aa;
      20: k = 32'hd62f105d;  21: k = 32'h02441453;  22: k = 32'hd8a1e681;  23: k = 32'he7d3fbc8;
      24: k = 32'h21e1cde6;  25: k = 32'hc33707d6;  26: k = 32'hf4d50d87;  27: k = 32'h455a14ed;
      28: k = 32'ha9e3e905;  29: k = 32'hfcefa3f8;  30: k = 32'h676f02d9;  31: k = 32'h8d2a4c8a;
      32: k = 32'hfffa3942;  33: k = 32'h8771f681;  34: k = 32'h6d9d6122;  35: k = 32'hfde5380c;
      36: k = 32'ha4beea44;  37: k = 32'h4bdecfa9;  38: k = 32'hf6bb4b60;  39: k = 32'hbebfbc70;
      40: k = 32'h289b7ec6;  41: k = 32'heaa127fa;  42: k = 32'hd4ef3085;  43: k = 32'h04881d05;
      44: k = 32'hd9d4d039;  45: k = 32'he6db99e5;  46: k = 32'h1fa27cf8;  47: k = 32'hc4ac5665;
      48: k = 32'hf4292244;  49: k = 32'h432aff97;  50: k = 32'hab9423a7;  51: k = 32'hfc93a039;
      52: k = 32'h655b59c3;  53: k = 32'h8f0ccc92;  54: k = 32'hffeff47d;  55: k = 32'h85845dd1;
      56: k = 32'h6fa87e4f;  57: k = 32'hfe2ce6e0;  58: k = 32'ha3014314;  59: k = 32'h4e0811a1;
      60: k = 32'hf7537e82;  61: k = 32'hbd3af235;  62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic void start_fresh();
    chain_val[0] = ChainA;
    chain_val[1] = ChainB;
    chain_val[2] = ChainC;
    chain_val[3] = ChainD;
    msg_bits = '0;
    fill_pos = '0;
  endfunction

  // Bytes sit little-endian within each 32-bit buffer word.
  function automatic void set_byte(input int unsigned slot, input logic [7:0] value);
    block_words[slot / 4][(slot % 4) * 8 +: 8] = value;
  endfunction

  // Runs the 64 rounds over the buffer and adds the outcome into the chaining value.
  function automatic void fold_block();
    logic [31:0] a, b, c, d, mix, sum;
    int unsigned g;
    logic [4:0]  amt;
    a = chain_val[0];
    b = chain_val[1];
    c = chain_val[2];
    d = chain_val[3];
    for (int unsigned i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          mix = (b & c) | (~b & d);
          g   = i;
        end
        1: begin
          mix = (d & b) | (~d & c);
          g   = (5 * i + 1) % 16;
        end
        2: begin
          mix = b ^ c ^ d;
          g   = (3 * i + 5) % 16;
        end
        default: begin
          mix = c ^ (b | ~d);
          g   = (7 * i) % 16;
        end
      endcase
      sum = a + mix + round_const(i) + block_words[g];
      amt = RotAmount[(i / 16) * 4 + i % 4];
      a = d;
      d = c;
      c = b;
      b = b + ((sum << amt) | (sum >> (32 - amt)));
    end
    chain_val[0] = chain_val[0] + a;
    chain_val[1] = chain_val[1] + b;
    chain_val[2] = chain_val[2] + c;
    chain_val[3] = chain_val[3] + d;
  endfunction

  // Folds one accepted item into the model. A final item pads the message, appends the 64-bit
  // length and leaves four digest words owed, A first; the model then starts a new message.
  function automatic void absorb_item(input md5_pkg::in_item_t item);
    md5_pkg::out_item_t word;
    int unsigned        tail;
    if (item.has_byte) begin
      set_byte(32'(fill_pos), item.data_byte);
      msg_bits = msg_bits + 64'd8;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) begin
        fold_block();
      end
    end
    if (item.final_item) begin
      tail = 32'(fill_pos);
      for (int unsigned k = tail; k < 64; k++) begin
        set_byte(k, (k == tail) ? PadMark : 8'h00);
      end
      // With no room left for the length, the marker closes this block and the length goes out in a block of its own.
      if (tail >= 56) begin
        fold_block();
        for (int unsigned w = 0; w < 16; w++) begin
          block_words[w] = '0;
        end
      end
      block_words[14] = msg_bits[31:0];
      block_words[15] = msg_bits[63:32];
      fold_block();
      for (int unsigned w = 0; w < 4; w++) begin
        word.digest_word = chain_val[w];
        word.word_index  = 2'(w);
        word.last_word   = (w == 3);
        digest_due.push_back(word);
      end
      start_fresh();
    end
  endfunction

  task automatic report_fault(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fault_count++;
  endtask

  function automatic void queue_item(input logic [7:0] data, input logic has, input logic fin);
    md5_pkg::in_item_t item;
    item.data_byte  = data;
    item.has_byte   = has;
    item.final_item = fin;
    message_items.push_back(item);
    if (has || fin) begin
      items_queued++;
    end
  endfunction

  // Mostly short messages, a good share that ends on or near a block boundary, a few long ones.
  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return $urandom_range(0, 12);
    end else if (roll < 80) begin
      return $urandom_range(13, 40);
    end else if (roll < 95) begin
      case ($urandom_range(0, 7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 120;
        default: return 127;
      endcase
    end
    return $urandom_range(100, 135);
  endfunction

  // One message of random bytes with the odd idle item mixed in. Half the time the final flag
  // rides on the last byte, otherwise a separate final item without a byte closes the message.
  function automatic void queue_message(input int unsigned len);
    bit flag_on_byte;
    flag_on_byte = 1'($urandom_range(0, 1));
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(0, 15) == 0) begin
        queue_item(8'($urandom), 1'b0, 1'b0);
      end
      queue_item(8'($urandom), 1'b1, flag_on_byte && (n == len - 1));
    end
    if (!flag_on_byte || len == 0) begin
      queue_item(8'($urandom), 1'b0, 1'b1);
    end
  endfunction

  // Sends everything queued, then holds the sender off until every owed word has come back.
  task automatic drain_all();
    while (message_items.size() != 0) begin
      @(posedge clk_i);
    end
    while (digest_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct);
    int unsigned goal;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    goal = items_queued + PhaseItems;
    while (items_queued < goal) begin
      queue_message(pick_length());
    end
    drain_all();
  endtask

  // Driver: a beat refused by full is held unchanged; otherwise the next item is offered unless
  // the sender decides to idle this cycle. While push is low the item lines carry noise.
  always @(negedge clk_i) begin
    if (!push || in_beat) begin
      send_go = (message_items.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
      push <= send_go;
      if (send_go) begin
        in_item_i <= message_items[0];
      end else begin
        in_item_i <= 10'($urandom_range(0, 1023));
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: sees both handshakes, updates the model, checks each digest word and watches for
  // a hang. A word that nobody is owed does not count as progress.
  always @(posedge clk_i) begin
    in_beat  = rst_ni && push && !full;
    out_beat = rst_ni && pop && !empty;
    out_owed = out_beat && (digest_due.size() != 0);

    if (in_beat) begin
      absorb_item(message_items.pop_front());
    end

    if (out_beat) begin
      if (digest_due.size() == 0) begin
        report_fault($sformatf("digest word %h with no message pending",
                               out_item_o.digest_word));
      end else begin
        want_word = digest_due.pop_front();
        if (out_item_o.digest_word !== want_word.digest_word) begin
          report_fault($sformatf("word %0d: digest_word %h, expected %h", want_word.word_index,
                                 out_item_o.digest_word, want_word.digest_word));
        end
        if (out_item_o.word_index !== want_word.word_index) begin
          report_fault($sformatf("word %0d: word_index %0d", want_word.word_index,
                                 out_item_o.word_index));
        end
        if (out_item_o.last_word !== want_word.last_word) begin
          report_fault($sformatf("word %0d: last_word %b, expected %b", want_word.word_index,
                                 out_item_o.last_word, want_word.last_word));
        end
      end
    end

    if (!rst_ni || in_beat || out_owed) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[%0t] ERROR: no beat for %0d cycles", $realtime, QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    start_fresh();
    for (int unsigned w = 0; w < 16; w++) begin
      block_words[w] = '0;
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, sent without idling.
    queue_item(8'hFF, 1'b0, 1'b1);  // empty message, data lines ignored
    queue_item(8'hFF, 1'b0, 1'b0);  // idle items change nothing
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1);  // single byte carrying the final flag
    queue_item(8'hFF, 1'b1, 1'b0);  // single byte closed by a final item without a byte
    queue_item(8'h5A, 1'b0, 1'b1);
    queue_item(8'h61, 1'b1, 1'b0);  // "abc", final flag on the last byte
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    queue_item(8'h80, 1'b1, 1'b0);  // idle item in the middle of a message
    queue_item(8'hC3, 1'b0, 1'b0);
    queue_item(8'h7F, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1);
    queue_item(8'h00, 1'b0, 1'b1);  // two empty messages back to back
    queue_item(8'hA5, 1'b0, 1'b1);
    drain_all();

    // Random part: free flow, a slow sender, a slow receiver, then both.
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(37, 37);

    // Keep popping for a while so that any stray word from the core is seen.
    recv_stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/md5_pkg.sv
rtl/md5_cmd_fifo.sv
rtl/md5_front.sv
rtl/md5_back.sv
rtl/md5_message_digest_core.sv
verif/tb_md5_message_digest_core.sv
